// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define PEDD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define PEDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pedd_pkg.sv
// ----------------------------------------------------------------------------
// pedd_pkg
// types, constants and arithmetic helpers of the palette dither block
// ----------------------------------------------------------------------------
package pedd_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int PALETTE_SIZE_DEF = 6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IMG_WIDTH_W = 11;
  localparam int CFG_PAL_COUNT = 6;

  localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RESET = 11'd64;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_0   = 3'd1;

  localparam logic [CFG_DATA_W-1:0] PAL_RESET [CFG_PAL_COUNT] = '{
    24'd1950304, 24'd8421631, 24'd11617456,
    24'd12897420, 24'd12884670, 24'd14511605
  };

  // diffusion weights over 16
  localparam logic [3:0] WGT_LEFT     = 4'd7;
  localparam logic [3:0] WGT_UP_LEFT  = 4'd1;
  localparam logic [3:0] WGT_UP       = 4'd5;
  localparam logic [3:0] WGT_UP_RIGHT = 4'd3;

  typedef logic [7:0]        pix_t;
  typedef logic signed [8:0] err_t;
  typedef logic [26:0]       err3_t;

  localparam pix_t PIX_MAX = 8'd255;

  // pixel after the row-above terms, on its way to the match stage
  typedef struct packed {
    pix_t [2:0] x;
    logic       col_nz;
    logic       row_last;
  } upix_t;

  typedef struct packed {
    logic [2:0] color_index;
    pix_t [2:0] chan;
    logic       row_end;
  } res_t;

  // line store write request
  typedef struct packed {
    logic  we;
    err3_t data;
  } wr_t;

  function automatic err_t err_field(input err3_t e, input int ch);
    err_field = $signed(e[9*ch +: 9]);
  endfunction

  // x + (wgt * e) / 16, truncated toward zero, clamped to 0..255
  function automatic pix_t add_term(input pix_t x, input logic [3:0] wgt, input err_t e);
    logic signed [13:0] prod;
    logic signed [13:0] adj;
    logic signed [10:0] s;
    prod = $signed({1'b0, wgt}) * e;
    adj  = prod[13] ? prod + 14'sd15 : prod;
    s    = $signed({3'b000, x}) + 11'(adj >>> 4);
    if (s < 11'sd0) begin
      add_term = '0;
    end else if (s > $signed({3'b000, PIX_MAX})) begin
      add_term = PIX_MAX;
    end else begin
      add_term = s[7:0];
    end
  endfunction

endpackage

// File: rtl/pedd_in_if.sv
// ----------------------------------------------------------------------------
// pedd_in_if
// pixel input channel, valid/ready
// ----------------------------------------------------------------------------
interface pedd_in_if import pedd_pkg::*; ();
  logic valid;
  logic ready;
  logic frame_start;
  pix_t chan0_in;
  pix_t chan1_in;
  pix_t chan2_in;

  modport source (output valid, frame_start, chan0_in, chan1_in, chan2_in, input ready);
  modport sink   (input valid, frame_start, chan0_in, chan1_in, chan2_in, output ready);
endinterface

// File: rtl/pedd_out_if.sv
// ----------------------------------------------------------------------------
// pedd_out_if
// palette result channel, valid/ready
// ----------------------------------------------------------------------------
interface pedd_out_if import pedd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] color_index;
  pix_t       chan0_out;
  pix_t       chan1_out;
  pix_t       chan2_out;
  logic       row_end;

  modport source (output valid, color_index, chan0_out, chan1_out, chan2_out, row_end,
                  input ready);
  modport sink   (input valid, color_index, chan0_out, chan1_out, chan2_out, row_end,
                  output ready);
endinterface

// File: rtl/pedd_match.sv
// ----------------------------------------------------------------------------
// pedd_match
// left-error term, palette distance search and quantization error
// ----------------------------------------------------------------------------
module pedd_match import pedd_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF,
  localparam int CW          = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          u_valid,
  input  upix_t         u_pix,
  input  logic [CW-1:0] u_col,
  output logic          u_take,
  input  logic [CFG_DATA_W-1:0] palette [PALETTE_SIZE],
  output logic          l_busy,
  input  logic          res_ready,
  output logic          res_valid,
  output res_t          res,
  output wr_t           wr,
  output logic [CW-1:0] wr_addr
);

  localparam int IW = $clog2(PALETTE_SIZE);

  logic                l_v_r;
  pix_t [2:0]          l_x_r;
  logic [2:0][15:0]    l_sq_r [PALETTE_SIZE];
  logic [CW-1:0]       l_col_r;
  logic                l_last_r;
  err3_t               left_err_r;

  pix_t [2:0]          xl_c;
  logic [2:0][15:0]    sq_c [PALETTE_SIZE];
  logic [IW-1:0]       best_c;
  logic [CFG_DATA_W-1:0] pal_best;
  err3_t               err_c;
  logic                d_fire;

  assign u_take = u_valid && !l_v_r;
  assign l_busy = l_v_r;
  assign d_fire = l_v_r && res_ready;

  // left term and squared channel distances
  always_comb begin
    logic signed [8:0]  dif;
    logic signed [17:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      xl_c[ch] = u_pix.col_nz ?
                 add_term(u_pix.x[ch], WGT_LEFT, err_field(left_err_r, ch)) : u_pix.x[ch];
    end
    for (int k = 0; k < PALETTE_SIZE; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        dif  = $signed({1'b0, xl_c[ch]} - {1'b0, palette[k][8*ch +: 8]});
        prod = dif * dif;
        sq_c[k][ch] = prod[15:0];
      end
    end
  end

  // nearest entry, lower index wins a tie
  always_comb begin
    logic [17:0] dsum;
    logic [17:0] best_d;
    best_c = '0;
    best_d = '0;
    for (int k = 0; k < PALETTE_SIZE; k++) begin
      dsum = 18'(l_sq_r[k][0]) + 18'(l_sq_r[k][1]) + 18'(l_sq_r[k][2]);
      if (k == 0 || dsum < best_d) begin
        best_d = dsum;
        best_c = IW'(k);
      end
    end
  end

  assign pal_best = palette[best_c];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      err_c[9*ch +: 9] = {1'b0, l_x_r[ch]} - {1'b0, pal_best[8*ch +: 8]};
    end
  end

  always_comb begin
    res.color_index = 3'(best_c);
    for (int ch = 0; ch < 3; ch++) begin
      res.chan[ch] = pal_best[8*ch +: 8];
    end
    res.row_end = l_last_r;
  end

  assign res_valid = d_fire;

  // one write port: left neighbor goes back on entry, own error on row end
  always_comb begin
    if (u_take) begin
      wr.we   = u_pix.col_nz;
      wr.data = left_err_r;
      wr_addr = u_col - 1'b1;
    end else begin
      wr.we   = d_fire && l_last_r;
      wr.data = err_c;
      wr_addr = l_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r      <= 1'b0;
      left_err_r <= '0;
    end else begin
      if (u_take) begin
        l_v_r <= 1'b1;
      end else if (d_fire) begin
        l_v_r <= 1'b0;
      end
      if (d_fire) begin
        left_err_r <= err_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (u_take) begin
      l_x_r    <= xl_c;
      l_sq_r   <= sq_c;
      l_col_r  <= u_col;
      l_last_r <= u_pix.row_last;
    end
  end

endmodule

// File: rtl/palette_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither
// floyd-steinberg error diffusion onto a small programmable palette
//
//   channel   direction  handshake         payload
//   in_pix    in         valid/ready       frame_start, chan0..2_in
//   out_res   out        valid/ready       color_index, chan0..2_out, row_end
//   cfg_*     in         cfg_we only       cfg_index, cfg_wdata
//
// the match stage holds one item at a time, so the loop from the left error
// through the distance search back into the next pixel's left term sets the rate
// the first item of a row after the first row waits until all earlier items
// have left the match stage, since it can read entries written by the
// previous row's last item; at image width 1 every item does so
// reset: synchronous active low, no clearing pass, the line store is not reset
// out_res stalls hold the result register; up to three more items wait behind
// it in the match, upper-term and front stages
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_error_diffusion_dither import pedd_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  pedd_in_if.sink                in_pix,
  pedd_out_if.source             out_res
);

  localparam int CW = $clog2(MAX_WIDTH);
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int WW = (CW + 1 > IMG_WIDTH_W) ? CW + 1 : IMG_WIDTH_W;

  // front sequencer: one pixel at a time, reads the row above ahead of it
  typedef enum logic [3:0] {
    FS_IDLE = 4'b0001,
    FS_RD0  = 4'b0010,
    FS_RD1  = 4'b0100,
    FS_USE  = 4'b1000
  } fs_t;

  // configuration
  logic [IMG_WIDTH_W-1:0] width_r;
  logic [CFG_DATA_W-1:0]  pal_r [PALETTE_SIZE];

  // position in the frame
  logic [CW-1:0] col_r;
  logic          first_r;

  // front slot
  fs_t           fs_r, fs_nxt;
  pix_t [2:0]    a_pix_r;
  logic [CW-1:0] a_col_r;
  logic          a_last_r;
  logic          a_first_r;

  // row-above window: entries j and j+1 of the last pixel through the front
  err3_t         prev_up_r;
  err3_t         prev_upr_r;
  logic          load_up_r;

  // upper-term stage
  logic          u_v_r;
  upix_t         u_pix_r;
  logic [CW-1:0] u_col_r;

  // line store of the previous row's errors
  err3_t         row_err_mem [MAX_WIDTH];
  err3_t         mem_rdata_r;
  logic          mem_re;
  logic [CW-1:0] mem_raddr;
  wr_t           mem_wr;
  logic [CW-1:0] mem_waddr;

  // output register
  logic          out_v_r;
  res_t          out_res_r;

  // match stage hookup
  logic          u_take;
  logic          l_busy;
  logic          res_ready;
  logic          res_valid;
  res_t          res;

  logic          accept;
  logic [CW-1:0] j_acc;
  logic          first_acc;
  logic          last_acc;
  logic [WW-1:0] w_ext;
  logic [WW-1:0] w_eff;
  logic          rd0_go;
  logic          rd1_go;
  pix_t [2:0]    ux_c;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= IMG_WIDTH_RESET;
      for (int k = 0; k < PALETTE_SIZE; k++) begin
        if (k < CFG_PAL_COUNT) begin
          pal_r[k] <= PAL_RESET[k];
        end else begin
          pal_r[k] <= '0;
        end
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_wdata[IMG_WIDTH_W-1:0];
      end
      for (int k = 0; k < PALETTE_SIZE; k++) begin
        if (k < CFG_PAL_COUNT && int'(cfg_index) == int'(REG_PALETTE_0) + k) begin
          pal_r[k] <= cfg_wdata;
        end
      end
    end
  end

  // ------------------------------------------------------- column tracking
  // width used clamped to 1..MAX_WIDTH
  assign w_ext = WW'(width_r);
  assign w_eff = (width_r == '0) ? WW'(1) :
                 (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;

  assign in_pix.ready = (fs_r == FS_IDLE) || (fs_r == FS_USE);
  assign accept       = in_pix.valid && in_pix.ready;

  // frame start restarts column and first-row state before the pixel
  assign j_acc     = in_pix.frame_start ? '0 : col_r;
  assign first_acc = in_pix.frame_start || first_r;
  assign last_acc  = (WW'(j_acc) + WW'(1) >= w_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else if (accept) begin
      col_r   <= last_acc ? '0 : j_acc + 1'b1;
      first_r <= last_acc ? 1'b0 : first_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r[0] <= in_pix.chan0_in;
      a_pix_r[1] <= in_pix.chan1_in;
      a_pix_r[2] <= in_pix.chan2_in;
      a_col_r    <= j_acc;
      a_last_r   <= last_acc;
      a_first_r  <= first_acc;
    end
  end

  // ------------------------------------------------------- front sequencer
  // row start of a later row: wait for the earlier row to drain, its last
  // item can write the entries this one reads
  assign rd0_go = (fs_r == FS_RD0) && (a_first_r || (!u_v_r && !l_busy));
  // upper-term stage must be free by the cycle the read data lands
  assign rd1_go = (fs_r == FS_RD1) && (!u_v_r || !l_busy);

  assign mem_re    = rd0_go || rd1_go;
  // row start reads entry 0 then entry 1, later columns read j+1 only
  assign mem_raddr = rd0_go ? '0 :
                     (a_col_r == CW'(MAX_WIDTH - 1)) ? '0 : a_col_r + 1'b1;

  always_comb begin
    fs_nxt = fs_r;
    case (fs_r)
      FS_IDLE, FS_USE: begin
        if (accept) begin
          fs_nxt = (j_acc == '0) ? FS_RD0 : FS_RD1;
        end else begin
          fs_nxt = FS_IDLE;
        end
      end
      FS_RD0: begin
        if (rd0_go) fs_nxt = FS_RD1;
      end
      FS_RD1: begin
        if (rd1_go) fs_nxt = FS_USE;
      end
      default: fs_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r      <= FS_IDLE;
      load_up_r <= 1'b0;
    end else begin
      fs_r      <= fs_nxt;
      load_up_r <= rd0_go;
    end
  end

  // ------------------------------------------------------------ line store
  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      row_err_mem[mem_waddr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= row_err_mem[mem_raddr];
    end
  end

  // ---------------------------------------------------- row-above terms
  // order per channel: upper-left 1/16, above 5/16, upper-right 3/16
  always_comb begin
    pix_t x;
    for (int ch = 0; ch < 3; ch++) begin
      x = a_pix_r[ch];
      if (!a_first_r) begin
        if (a_col_r != '0) begin
          x = add_term(x, WGT_UP_LEFT, err_field(prev_up_r, ch));
        end
        x = add_term(x, WGT_UP, err_field(prev_upr_r, ch));
        if (!a_last_r) begin
          x = add_term(x, WGT_UP_RIGHT, err_field(mem_rdata_r, ch));
        end
      end
      ux_c[ch] = x;
    end
  end

  // window slides by one entry per pixel; row start preloads entry 0
  always_ff @(posedge clk) begin
    if (load_up_r) begin
      prev_upr_r <= mem_rdata_r;
    end else if (fs_r == FS_USE) begin
      prev_up_r  <= prev_upr_r;
      prev_upr_r <= mem_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (fs_r == FS_USE) begin
      u_v_r <= 1'b1;
    end else if (u_take) begin
      u_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fs_r == FS_USE) begin
      u_pix_r.x        <= ux_c;
      u_pix_r.col_nz   <= (a_col_r != '0);
      u_pix_r.row_last <= a_last_r;
      u_col_r          <= a_col_r;
    end
  end

  // ---------------------------------------------------------- match stage
  assign res_ready = !out_v_r || out_res.ready;

  pedd_match #(
    .MAX_WIDTH    (MAX_WIDTH),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .u_valid   (u_v_r),
    .u_pix     (u_pix_r),
    .u_col     (u_col_r),
    .u_take    (u_take),
    .palette   (pal_r),
    .l_busy    (l_busy),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res),
    .wr        (mem_wr),
    .wr_addr   (mem_waddr)
  );

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_res.valid       = out_v_r;
  assign out_res.color_index = out_res_r.color_index;
  assign out_res.chan0_out   = out_res_r.chan[0];
  assign out_res.chan1_out   = out_res_r.chan[1];
  assign out_res.chan2_out   = out_res_r.chan[2];
  assign out_res.row_end     = out_res_r.row_end;

  // ------------------------------------------------------------ assertions
  `PEDD_ASSERT(a_out_no_overrun, res_valid |-> (!out_v_r || out_res.ready), "result overrun")
  `PEDD_ASSERT(a_ustage_free, (fs_r == FS_USE) |-> (!u_v_r || u_take), "upper stage overrun")
  `PEDD_ASSERT_NEXT(a_ustage_filled, fs_r == FS_USE, u_v_r, "upper stage not loaded")
  `PEDD_ASSERT(a_one_write_port, u_take |-> !res_valid, "match entry and exit together")

endmodule

// File: verif/tb_palette_error_diffusion_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_error_diffusion_dither
// drives pixel frames through the ditherer under bursty input and a stalling
// output, predicts each chosen palette entry in the bench and compares every
// result in order, across several widths and palettes
// ----------------------------------------------------------------------------
module tb_palette_error_diffusion_dither;
  import pedd_pkg::*;

  // diffusion weights over 16, as applied to each neighbor's error
  localparam int WT_LEFT        = 7;
  localparam int WT_ABOVE_LEFT  = 1;
  localparam int WT_ABOVE       = 5;
  localparam int WT_ABOVE_RIGHT = 3;
  localparam int WT_DIV         = 16;
  localparam int PIX_TOP        = 255;

  // index past the last palette register, decodes to nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED =
    CFG_INDEX_W'(int'(REG_PALETTE_0) + CFG_PAL_COUNT);

  // palette used by the directed rows
  localparam logic [CFG_DATA_W-1:0] COL_BLACK = 24'h000000;
  localparam logic [CFG_DATA_W-1:0] COL_WHITE = 24'hFFFFFF;
  localparam logic [CFG_DATA_W-1:0] COL_RED   = 24'h0000FF;
  localparam logic [CFG_DATA_W-1:0] COL_GREEN = 24'h00FF00;
  localparam logic [CFG_DATA_W-1:0] COL_BLUE  = 24'hFF0000;
  localparam logic [CFG_DATA_W-1:0] COL_GREY  = 24'h808080;

  localparam int DIR_ROWS    = 25;
  localparam int RAND_ITEMS  = 560;
  localparam int WIDE_EXTRA  = 8;    // pixels into the second full-width row
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    logic [2:0] idx;
    pix_t       ch0;
    pix_t       ch1;
    pix_t       ch2;
    logic       row_end;
  } pal_hit_t;

  // one line of the directed part: a register write or a pixel
  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    bit                     fs;
    pix_t                   c0;
    pix_t                   c1;
    pix_t                   c2;
    bit                     typed;
    pal_hit_t               want;
  } dir_row_t;

  bit clk;
  bit rst_n;
  bit cfg_we;
  bit [CFG_INDEX_W-1:0] cfg_index;
  bit [CFG_DATA_W-1:0]  cfg_wdata;
  bit rx_ready;
  int unsigned rx_hold;

  pedd_in_if  in_if ();
  pedd_out_if out_if ();

  assign out_if.ready = rx_ready;

  palette_error_diffusion_dither u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_if),
    .out_res   (out_if)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // bench copy of the ditherer state
  // --------------------------------------------------------------------------
  logic [IMG_WIDTH_W-1:0] cur_width;
  logic [CFG_DATA_W-1:0]  pal_tab [PALETTE_SIZE_DEF];
  err3_t                  err_row [MAX_WIDTH_DEF];
  bit                     row_seen [MAX_WIDTH_DEF];   // column written since reset
  err3_t                  err_left;
  int                     col_pos;
  bit                     top_row;

  pal_hit_t    dither_exp_q [$];
  int unsigned err_count;
  int unsigned burst_left;
  int unsigned rnd_items;

  // width register as the block uses it, 0 as 1 and capped at the store depth
  function automatic int cols_per_row();
    int w;
    w = int'(cur_width);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int err_of(err3_t word, int ch);
    err_t f;
    f = word[9*ch +: 9];
    return int'(f);
  endfunction

  // add one weighted error term, truncated toward zero, then clamp
  function automatic int spread(int x, int wgt, int e);
    int s;
    s = x + (wgt * e) / WT_DIV;
    if (s < 0) return 0;
    if (s > PIX_TOP) return PIX_TOP;
    return s;
  endfunction

  function automatic void note_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) begin
      cur_width = val[IMG_WIDTH_W-1:0];
    end else if (idx >= REG_PALETTE_0 && idx < REG_PALETTE_0 + CFG_PAL_COUNT) begin
      pal_tab[idx - REG_PALETTE_0] = val;
    end
  endfunction

  // true when the next pixel reads only line store entries written before
  function automatic bit store_ready_for(bit fs);
    int j;
    bit last;
    if (fs || top_row) return 1'b1;
    j = col_pos % MAX_WIDTH_DEF;
    last = (j + 1 >= cols_per_row());
    if (!row_seen[j]) return 1'b0;
    if (j >= 1 && !row_seen[j-1]) return 1'b0;
    if (!last && !row_seen[j+1]) return 1'b0;
    return 1'b1;
  endfunction

  // diffuse, pick the nearest palette entry and update the error state
  function automatic pal_hit_t dither_predict(bit fs, pix_t c0, pix_t c1, pix_t c2);
    int       j, best, best_d, d, t, ch, k;
    bit       last;
    int       v [3];
    int       e [3];
    err3_t    above, above_l, above_r, fresh;
    pal_hit_t hit;
    if (fs) begin
      col_pos  = 0;
      err_left = '0;
      top_row  = 1'b1;
    end
    j = col_pos % MAX_WIDTH_DEF;
    last = (j + 1 >= cols_per_row());
    above   = '0;
    above_l = '0;
    above_r = '0;
    if (!top_row) begin
      above = err_row[j];
      if (j >= 1) above_l = err_row[j-1];
      if (!last) above_r = err_row[j+1];
    end
    v[0] = int'(c0);
    v[1] = int'(c1);
    v[2] = int'(c2);
    // term order matters because of the clamp after each addition
    for (ch = 0; ch < 3; ch++) begin
      if (!top_row) begin
        if (j >= 1) v[ch] = spread(v[ch], WT_ABOVE_LEFT, err_of(above_l, ch));
        v[ch] = spread(v[ch], WT_ABOVE, err_of(above, ch));
        if (!last) v[ch] = spread(v[ch], WT_ABOVE_RIGHT, err_of(above_r, ch));
      end
      if (j >= 1) v[ch] = spread(v[ch], WT_LEFT, err_of(err_left, ch));
    end
    // exact squared distance, strict less keeps the lower index on a tie
    best   = 0;
    best_d = 0;
    for (k = 0; k < PALETTE_SIZE_DEF; k++) begin
      d = 0;
      for (ch = 0; ch < 3; ch++) begin
        t = v[ch] - int'(pal_tab[k][8*ch +: 8]);
        d += t * t;
      end
      if (k == 0 || d < best_d) begin
        best_d = d;
        best   = k;
      end
    end
    for (ch = 0; ch < 3; ch++) begin
      e[ch] = v[ch] - int'(pal_tab[best][8*ch +: 8]);
      fresh[9*ch +: 9] = e[ch][8:0];
    end
    // the left neighbor's error lands in the store once it is no longer needed
    if (j >= 1) begin
      err_row[j-1]  = err_left;
      row_seen[j-1] = 1'b1;
    end
    err_left = fresh;
    if (last) begin
      err_row[j]  = fresh;
      row_seen[j] = 1'b1;
      col_pos     = 0;
      top_row     = 1'b0;
    end else begin
      col_pos = j + 1;
    end
    hit.idx     = best[2:0];
    hit.ch0     = pal_tab[best][7:0];
    hit.ch1     = pal_tab[best][15:8];
    hit.ch2     = pal_tab[best][23:16];
    hit.row_end = last;
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pix_t pick_chan();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t pix_row(bit fs, pix_t c0, pix_t c1, pix_t c2);
    dir_row_t r;
    r = '{default: '0};
    r.fs = fs;
    r.c0 = c0;
    r.c1 = c1;
    r.c2 = c2;
    return r;
  endfunction

  // pixel whose result is obvious from the palette, typed in directly
  function automatic dir_row_t typed_row(bit fs, pix_t c0, pix_t c1, pix_t c2,
                                         logic [2:0] idx, pix_t w0, pix_t w1, pix_t w2,
                                         bit re);
    dir_row_t r;
    r = pix_row(fs, c0, c1, c2);
    r.typed = 1'b1;
    r.want  = '{idx, w0, w1, w2, re};
    return r;
  endfunction

  // register write, only called with the block idle
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    note_cfg(idx, val);
    @(posedge clk);
  endtask

  // one pixel item; the sender runs in bursts separated by random gaps
  task automatic send_pixel(input bit fs, input pix_t c0, input pix_t c1, input pix_t c2,
                            input bit typed, input pal_hit_t want);
    int unsigned gap;
    pal_hit_t    hit;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.frame_start <= fs;
    in_if.chan0_in    <= c0;
    in_if.chan1_in    <= c1;
    in_if.chan2_in    <= c2;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // valid stays up here; the next item or an idle step replaces it
    hit = dither_predict(fs, c0, c1, c2);
    dither_exp_q.push_back(typed ? want : hit);
  endtask

  // block idle: no item offered and every result back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (dither_exp_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result side: stall pattern and in-order check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          rx_ready <= 1'b0;
          rx_hold  <= $urandom_range(0, 5);
        end
        1: begin
          // long stall-free stretch
          rx_ready <= 1'b1;
          rx_hold  <= $urandom_range(20, 80);
        end
        default: begin
          rx_ready <= ~rx_ready;
          rx_hold  <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    pal_hit_t got, want;
    if (rst_n && out_if.valid && rx_ready) begin
      got = '{out_if.color_index, out_if.chan0_out, out_if.chan1_out, out_if.chan2_out,
              out_if.row_end};
      if (dither_exp_q.size() == 0) begin
        if (err_count < SHOW_ERRORS)
          $display("unexpected result: idx %0d ch %0d/%0d/%0d end %0d",
                   got.idx, got.ch0, got.ch1, got.ch2, got.row_end);
        err_count++;
      end else begin
        want = dither_exp_q.pop_front();
        if (got.idx !== want.idx || got.ch0 !== want.ch0 || got.ch1 !== want.ch1 ||
            got.ch2 !== want.ch2 || got.row_end !== want.row_end) begin
          if (err_count < SHOW_ERRORS)
            $display("mismatch: want idx %0d ch %0d/%0d/%0d end %0d, got idx %0d ch %0d/%0d/%0d end %0d",
                     want.idx, want.ch0, want.ch1, want.ch2, want.row_end,
                     got.idx, got.ch0, got.ch1, got.ch2, got.row_end);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t               dir_tab [DIR_ROWS];
    int                     n_pix, k, sel, mode;
    bit                     fs;
    logic [CFG_DATA_W-1:0]  val, prev;
    logic [IMG_WIDTH_W-1:0] w_new;

    in_if.valid       <= 1'b0;
    in_if.frame_start <= 1'b0;
    in_if.chan0_in    <= '0;
    in_if.chan1_in    <= '0;
    in_if.chan2_in    <= '0;

    // bench state after reset
    cur_width = IMG_WIDTH_RESET;
    for (k = 0; k < PALETTE_SIZE_DEF; k++) pal_tab[k] = PAL_RESET[k];
    err_left   = '0;
    col_pos    = 0;
    top_row    = 1'b1;
    err_count  = 0;
    burst_left = 0;
    rnd_items  = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    dir_tab = '{
      // reset palette, exact hit on entry 0, width 64 so no row end
      typed_row(1'b1, 8'd96, 8'd194, 8'd29, 3'd0, 8'd96, 8'd194, 8'd29, 1'b0),
      // width 0 behaves as 1
      cfg_row(REG_IMAGE_WIDTH, 24'd0),
      cfg_row(REG_PALETTE_0 + 3'd0, COL_BLACK),
      cfg_row(REG_PALETTE_0 + 3'd1, COL_WHITE),
      cfg_row(REG_PALETTE_0 + 3'd2, COL_RED),
      cfg_row(REG_PALETTE_0 + 3'd3, COL_GREEN),
      cfg_row(REG_PALETTE_0 + 3'd4, COL_BLUE),
      cfg_row(REG_PALETTE_0 + 3'd5, COL_GREY),
      typed_row(1'b1, 8'd0, 8'd0, 8'd0, 3'd0, 8'd0, 8'd0, 8'd0, 1'b1),
      // second row of a one-pixel image, zero error from above
      typed_row(1'b0, 8'd255, 8'd255, 8'd255, 3'd1, 8'd255, 8'd255, 8'd255, 1'b1),
      // equal distance to black and grey, lower index wins
      typed_row(1'b1, 8'd64, 8'd64, 8'd64, 3'd0, 8'd0, 8'd0, 8'd0, 1'b1),
      // width above the store depth is capped
      cfg_row(REG_IMAGE_WIDTH, 24'd2047),
      typed_row(1'b1, 8'd255, 8'd0, 8'd0, 3'd2, 8'd255, 8'd0, 8'd0, 1'b0),
      // three-wide frame with strong errors, clamping at both ends
      cfg_row(REG_IMAGE_WIDTH, 24'd3),
      pix_row(1'b1, 8'd200, 8'd30, 8'd250),
      pix_row(1'b0, 8'd255, 8'd255, 8'd0),
      pix_row(1'b0, 8'd0, 8'd0, 8'd255),
      pix_row(1'b0, 8'd255, 8'd0, 8'd255),
      pix_row(1'b0, 8'd10, 8'd250, 8'd128),
      pix_row(1'b0, 8'd255, 8'd255, 8'd255),
      pix_row(1'b0, 8'd0, 8'd0, 8'd0),
      cfg_row(REG_UNUSED, 24'hA5A5A5),
      // shrink the width mid-row: column 1 is past the new last column
      cfg_row(REG_IMAGE_WIDTH, 24'd1),
      pix_row(1'b0, 8'd128, 8'd128, 8'd128),
      pix_row(1'b0, 8'd77, 8'd200, 8'd3)
    };
    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        wait_drained();
        write_reg(dir_tab[r].reg_idx, dir_tab[r].reg_val);
      end else begin
        send_pixel(dir_tab[r].fs, dir_tab[r].c0, dir_tab[r].c1, dir_tab[r].c2,
                   dir_tab[r].typed, dir_tab[r].want);
      end
    end

    // random phases: new width and palette, then mostly well-formed frames
    while (rnd_items < RAND_ITEMS) begin
      wait_drained();
      sel = $urandom_range(0, 19);
      if (sel == 0)       w_new = '0;
      else if (sel == 1)  w_new = IMG_WIDTH_W'($urandom_range(MAX_WIDTH_DEF + 1, 2047));
      else if (sel < 12)  w_new = IMG_WIDTH_W'($urandom_range(1, 8));
      else if (sel < 18)  w_new = IMG_WIDTH_W'($urandom_range(9, 40));
      else                w_new = IMG_WIDTH_W'($urandom_range(41, 64));
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_new));

      mode = $urandom_range(0, 5);
      prev = '0;
      if (mode != 5) begin
        for (k = 0; k < CFG_PAL_COUNT; k++) begin
          case (mode)
            0: val = CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
            1: val = PAL_RESET[k];
            // only the two extremes, so every search ends in a tie
            2: val = (k % 2 == 1) ? COL_WHITE : COL_BLACK;
            // repeated entries
            3: val = (k != 0 && $urandom_range(0, 1) == 1) ? prev
                                                            : CFG_DATA_W'($urandom_range(0, 24'hFFFFFF));
            // corners of the color cube
            default: val = {($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                            ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00,
                            ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00};
          endcase
          write_reg(REG_PALETTE_0 + CFG_INDEX_W'(k), val);
          prev = val;
        end
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));

      // most phases open a frame, the rest carry on with the new width mid-row
      n_pix = $urandom_range(6, 90);
      for (k = 0; k < n_pix; k++) begin
        if (k == 0) fs = ($urandom_range(0, 4) != 0);
        else        fs = ($urandom_range(0, 49) == 0);
        // never read a line store column that was never written
        if (!store_ready_for(fs)) fs = 1'b1;
        send_pixel(fs, pick_chan(), pick_chan(), pick_chan(), 1'b0, '0);
        rnd_items++;
      end
    end

    // one full row at the store depth and the start of the next
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_WIDTH_DEF));
    for (k = 0; k < MAX_WIDTH_DEF + WIDE_EXTRA; k++)
      send_pixel(k == 0, pick_chan(), pick_chan(), pick_chan(), 1'b0, '0);

    wait_drained();
    repeat (16) @(posedge clk);
    if (err_count == 0 && dither_exp_q.size() == 0) begin
      $display("** palette_error_diffusion_dither: PASSED **");
    end else begin
      $display("** palette_error_diffusion_dither: FAILED **");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("** palette_error_diffusion_dither: FAILED **");
    $finish;
  end

endmodule
